// ----- hw/rtl/lacb_pkg.sv -----
package lacb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NORM_MSB      = 30;
  localparam int COMP_W        = 18;
  localparam int COORD_W       = 32;
  localparam int ROW_W         = 2;

  localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
  localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;

endpackage

// ----- hw/rtl/lacb_cross.sv -----
module lacb_cross #(
  parameter int AW = 32,
  parameter int BW = 18,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [AW-1:0] in_a0,
  input  logic signed [AW-1:0] in_a1,
  input  logic signed [AW-1:0] in_a2,
  input  logic signed [BW-1:0] in_b0,
  input  logic signed [BW-1:0] in_b1,
  input  logic signed [BW-1:0] in_b2,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [AW+BW:0] out_r0,
  output logic signed [AW+BW:0] out_r1,
  output logic signed [AW+BW:0] out_r2,
  output logic [SW-1:0]        out_side
);

  localparam int PW = AW + BW;
  localparam int RW = AW + BW + 1;

  logic signed [PW-1:0] p_nxt [6];
  logic signed [PW-1:0] p_r [6];
  logic                 v1_r;
  logic [SW-1:0]        side1_r;
  logic signed [RW-1:0] r_nxt [3];
  logic signed [RW-1:0] r_r [3];
  logic                 v2_r;
  logic [SW-1:0]        side2_r;

  always_comb begin
    p_nxt[0] = in_a1 * in_b2;
    p_nxt[1] = in_a2 * in_b1;
    p_nxt[2] = in_a2 * in_b0;
    p_nxt[3] = in_a0 * in_b2;
    p_nxt[4] = in_a0 * in_b1;
    p_nxt[5] = in_a1 * in_b0;
  end

  always_comb begin
    r_nxt[0] = RW'(p_r[0]) - RW'(p_r[1]);
    r_nxt[1] = RW'(p_r[2]) - RW'(p_r[3]);
    r_nxt[2] = RW'(p_r[4]) - RW'(p_r[5]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 6; k++) begin
      p_r[k] <= p_nxt[k];
    end
    for (int k = 0; k < 3; k++) begin
      r_r[k] <= r_nxt[k];
    end
    side1_r <= in_side;
    side2_r <= side1_r;
  end

  assign out_valid = v2_r;
  assign out_r0    = r_r[0];
  assign out_r1    = r_r[1];
  assign out_r2    = r_r[2];
  assign out_side  = side2_r;

endmodule

// ----- hw/rtl/lacb_norm.sv -----
module lacb_norm #(
  parameter int IW = 33,
  parameter int FB = 16,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] in_c0,
  input  logic signed [IW-1:0] in_c1,
  input  logic signed [IW-1:0] in_c2,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [FB+1:0] out_c0,
  output logic signed [FB+1:0] out_c1,
  output logic signed [FB+1:0] out_c2,
  output logic                 out_zero,
  output logic [SW-1:0]        out_side
);
  import lacb_pkg::*;

  localparam int PB    = $clog2(IW);
  localparam int MW    = NORM_MSB + 1;
  localparam int SQW   = 2 * MW;
  localparam int SUMW  = SQW + 2;
  localparam int NSTEP = SUMW / 2;
  localparam int RW    = SUMW / 2;
  localparam int QW    = FB + 1;
  localparam int DW    = MW + FB + 1;
  localparam int OW    = FB + 2;

  // stage 0: magnitudes
  logic signed [IW-1:0] c_in [3];
  logic [IW-1:0]        mag0_nxt [3];
  logic [2:0]           neg0_nxt;
  logic                 zero0_nxt;
  logic                 v0_r;
  logic [IW-1:0]        mag0_r [3];
  logic [2:0]           neg0_r;
  logic                 zero0_r;
  logic [SW-1:0]        side0_r;

  assign c_in[0] = in_c0;
  assign c_in[1] = in_c1;
  assign c_in[2] = in_c2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg0_nxt[k] = c_in[k][IW-1];
      mag0_nxt[k] = neg0_nxt[k] ? IW'(-c_in[k]) : IW'(c_in[k]);
    end
    zero0_nxt = (c_in[0] == '0) && (c_in[1] == '0) && (c_in[2] == '0);
  end

  // stage 1: largest magnitude
  logic [IW-1:0] mx01;
  logic [IW-1:0] mx1_nxt;
  logic          v1_r;
  logic [IW-1:0] mx1_r;
  logic [IW-1:0] mag1_r [3];
  logic [2:0]    neg1_r;
  logic          zero1_r;
  logic [SW-1:0] side1_r;

  always_comb begin
    mx01    = (mag0_r[0] > mag0_r[1]) ? mag0_r[0] : mag0_r[1];
    mx1_nxt = (mx01 > mag0_r[2]) ? mx01 : mag0_r[2];
  end

  // stage 2: leading one position
  logic [PB-1:0] p2_nxt;
  logic          v2_r;
  logic [PB-1:0] p2_r;
  logic [IW-1:0] mag2_r [3];
  logic [2:0]    neg2_r;
  logic          zero2_r;
  logic [SW-1:0] side2_r;

  always_comb begin
    p2_nxt = '0;
    for (int i = 0; i < IW; i++) begin
      if (mx1_r[i]) p2_nxt = PB'(i);
    end
  end

  // stage 3: leading one of the largest to bit NORM_MSB
  logic [PB:0]      shamt;
  logic [IW+MW-1:0] wide [3];
  logic [MW-1:0]    m3_nxt [3];
  logic             v3_r;
  logic [MW-1:0]    m3_r [3];
  logic [2:0]       neg3_r;
  logic             zero3_r;
  logic [SW-1:0]    side3_r;

  always_comb begin
    shamt = (PB+1)'(p2_r) + (PB+1)'(1);
    for (int k = 0; k < 3; k++) begin
      wide[k]   = {mag2_r[k], MW'(0)} >> shamt;
      m3_nxt[k] = wide[k][MW-1:0];
    end
  end

  // stage 4: squares
  logic [SQW-1:0] sq4_nxt [3];
  logic           v4_r;
  logic [SQW-1:0] sq4_r [3];
  logic [MW-1:0]  m4_r [3];
  logic [2:0]     neg4_r;
  logic           zero4_r;
  logic [SW-1:0]  side4_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq4_nxt[k] = m3_r[k] * m3_r[k];
    end
  end

  // square root steps, index 0 holds the sum of squares
  logic [SUMW-1:0] sum_nxt;
  logic            sv_r    [NSTEP+1];
  logic [SUMW-1:0] sa_r    [NSTEP+1];
  logic [SUMW-1:0] sres_r  [NSTEP+1];
  logic [MW-1:0]   sm_r    [NSTEP+1][3];
  logic [2:0]      sneg_r  [NSTEP+1];
  logic            szero_r [NSTEP+1];
  logic [SW-1:0]   sside_r [NSTEP+1];

  assign sum_nxt = SUMW'(sq4_r[0]) + SUMW'(sq4_r[1]) + SUMW'(sq4_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r     <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      v4_r     <= 1'b0;
      sv_r[0]  <= 1'b0;
    end else begin
      v0_r     <= in_valid;
      v1_r     <= v0_r;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      v4_r     <= v3_r;
      sv_r[0]  <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mag0_r[k]   <= mag0_nxt[k];
      mag1_r[k]   <= mag0_r[k];
      mag2_r[k]   <= mag1_r[k];
      m3_r[k]     <= m3_nxt[k];
      m4_r[k]     <= m3_r[k];
      sq4_r[k]    <= sq4_nxt[k];
      sm_r[0][k]  <= m4_r[k];
    end
    neg0_r     <= neg0_nxt;
    neg1_r     <= neg0_r;
    neg2_r     <= neg1_r;
    neg3_r     <= neg2_r;
    neg4_r     <= neg3_r;
    sneg_r[0]  <= neg4_r;
    zero0_r    <= zero0_nxt;
    zero1_r    <= zero0_r;
    zero2_r    <= zero1_r;
    zero3_r    <= zero2_r;
    zero4_r    <= zero3_r;
    szero_r[0] <= zero4_r;
    side0_r    <= in_side;
    side1_r    <= side0_r;
    side2_r    <= side1_r;
    side3_r    <= side2_r;
    side4_r    <= side3_r;
    sside_r[0] <= side4_r;
    mx1_r      <= mx1_nxt;
    p2_r       <= p2_nxt;
    sa_r[0]    <= sum_nxt;
    sres_r[0]  <= '0;
  end

  for (genvar s = 0; s < NSTEP; s++) begin : g_sqrt
    localparam logic [SUMW-1:0] BIT = SUMW'(1) << (SUMW - 2 - 2 * s);
    logic [SUMW-1:0] trial;
    logic            ge;
    logic [SUMW-1:0] a_nxt;
    logic [SUMW-1:0] res_nxt;

    always_comb begin
      trial   = sres_r[s] + BIT;
      ge      = sa_r[s] >= trial;
      a_nxt   = ge ? (sa_r[s] - trial) : sa_r[s];
      res_nxt = ge ? ((sres_r[s] >> 1) + BIT) : (sres_r[s] >> 1);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[s+1] <= 1'b0;
      end else begin
        sv_r[s+1] <= sv_r[s];
      end
    end

    always_ff @(posedge clk) begin
      sa_r[s+1]    <= a_nxt;
      sres_r[s+1]  <= res_nxt;
      for (int k = 0; k < 3; k++) begin
        sm_r[s+1][k] <= sm_r[s][k];
      end
      sneg_r[s+1]  <= sneg_r[s];
      szero_r[s+1] <= szero_r[s];
      sside_r[s+1] <= sside_r[s];
    end
  end

  // divide steps, index 0 holds the rounded dividends
  logic [RW-1:0] len;
  logic [DW-1:0] dd [3];
  logic          dv_r    [QW+1];
  logic [RW-1:0] drem_r  [QW+1][3];
  logic [QW-1:0] dql_r   [QW+1][3];
  logic [RW-1:0] dlen_r  [QW+1];
  logic [2:0]    dneg_r  [QW+1];
  logic          dzero_r [QW+1];
  logic [SW-1:0] dside_r [QW+1];

  assign len = sres_r[NSTEP][RW-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dd[k] = (DW'(sm_r[NSTEP][k]) << FB) + DW'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= sv_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      drem_r[0][k] <= RW'(dd[k][DW-1:QW]);
      dql_r[0][k]  <= dd[k][QW-1:0];
    end
    dlen_r[0]  <= len;
    dneg_r[0]  <= sneg_r[NSTEP];
    dzero_r[0] <= szero_r[NSTEP];
    dside_r[0] <= sside_r[NSTEP];
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW:0]   t [3];
    logic [2:0]    ge;
    logic [RW-1:0] rem_nxt [3];
    logic [QW-1:0] ql_nxt [3];

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        t[k]       = {drem_r[j][k], dql_r[j][k][QW-1]};
        ge[k]      = t[k] >= {1'b0, dlen_r[j]};
        rem_nxt[k] = ge[k] ? RW'(t[k] - {1'b0, dlen_r[j]}) : t[k][RW-1:0];
        ql_nxt[k]  = {dql_r[j][k][QW-2:0], ge[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else begin
        dv_r[j+1] <= dv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) begin
        drem_r[j+1][k] <= rem_nxt[k];
        dql_r[j+1][k]  <= ql_nxt[k];
      end
      dlen_r[j+1]  <= dlen_r[j];
      dneg_r[j+1]  <= dneg_r[j];
      dzero_r[j+1] <= dzero_r[j];
      dside_r[j+1] <= dside_r[j];
    end
  end

  // clamp, sign
  localparam logic [QW-1:0] ONE = QW'(1) << FB;
  logic [QW-1:0]        qc [3];
  logic signed [OW-1:0] qe [3];
  logic signed [OW-1:0] res_nxt [3];
  logic                 ov_r;
  logic signed [OW-1:0] res_r [3];
  logic                 ozero_r;
  logic [SW-1:0]        oside_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k] = (dql_r[QW][k] > ONE) ? ONE : dql_r[QW][k];
      qe[k] = $signed({1'b0, qc[k]});
      if (dzero_r[QW]) begin
        res_nxt[k] = '0;
      end else if (dneg_r[QW][k]) begin
        res_nxt[k] = -qe[k];
      end else begin
        res_nxt[k] = qe[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= dv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      res_r[k] <= res_nxt[k];
    end
    ozero_r <= dzero_r[QW];
    oside_r <= dside_r[QW];
  end

  assign out_valid = ov_r;
  assign out_c0    = res_r[0];
  assign out_c1    = res_r[1];
  assign out_c2    = res_r[2];
  assign out_zero  = ozero_r;
  assign out_side  = oside_r;

endmodule

// ----- hw/rtl/look_at_camera_basis_top.sv -----
// Look-at camera basis. Pulse start while busy is low to hand in one transaction
// (eye, target, up in signed Q16.16); busy then stays high, and no new
// transaction is taken until it falls, which paces the input to the three-row
// output burst. The datapath is one pipeline of three normalizers (each with
// magnitude stages, 32 square-root steps and divide steps) and two
// cross-product stages; the first row appears after the eye-minus-target
// register, the normalizers and cross products in turn, and the row serializer,
// followed by the other two rows on consecutive cycles, each marked by out_strobe for one cycle.
// The receiver cannot stall: every row must be taken when strobed.
module look_at_camera_basis_top #(
  parameter int FRAC_BITS = lacb_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [lacb_pkg::COORD_W-1:0] in_eye_x,
  input  logic signed [lacb_pkg::COORD_W-1:0] in_eye_y,
  input  logic signed [lacb_pkg::COORD_W-1:0] in_eye_z,
  input  logic signed [lacb_pkg::COORD_W-1:0] in_target_x,
  input  logic signed [lacb_pkg::COORD_W-1:0] in_target_y,
  input  logic signed [lacb_pkg::COORD_W-1:0] in_target_z,
  input  logic signed [lacb_pkg::COORD_W-1:0] in_upward_x,
  input  logic signed [lacb_pkg::COORD_W-1:0] in_upward_y,
  input  logic signed [lacb_pkg::COORD_W-1:0] in_upward_z,
  output logic                                out_strobe,
  output logic [lacb_pkg::ROW_W-1:0]          out_row_index,
  output logic signed [lacb_pkg::COMP_W-1:0]  out_right_comp,
  output logic signed [lacb_pkg::COMP_W-1:0]  out_true_up_comp,
  output logic signed [lacb_pkg::COMP_W-1:0]  out_back_comp,
  output logic signed [lacb_pkg::COORD_W-1:0] out_translation,
  output logic                                out_last_row,
  output logic                                out_degenerate
);
  import lacb_pkg::*;

  localparam int CW  = COORD_W;
  localparam int DFW = CW + 1;
  localparam int OW  = FRAC_BITS + 2;
  localparam int UW  = CW + OW + 1;
  localparam int VW  = 2 * OW + 1;
  localparam int SNW = 6 * CW;
  localparam int SUW = 3 * OW + 3 * CW + 1;
  localparam int SVW = 6 * OW + 3 * CW + 1;

  // input throttle
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       accept;

  assign accept = start && !busy;
  assign busy   = (cnt_r != 2'd0);

  always_comb begin
    if (accept) begin
      cnt_nxt = 2'd2;
    end else if (cnt_r != 2'd0) begin
      cnt_nxt = cnt_r - 2'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // eye minus target
  logic                  dv_r;
  logic signed [DFW-1:0] dn_r [3];
  logic [SNW-1:0]        dside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      dv_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      dv_r  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    dn_r[0] <= DFW'(in_eye_x) - DFW'(in_target_x);
    dn_r[1] <= DFW'(in_eye_y) - DFW'(in_target_y);
    dn_r[2] <= DFW'(in_eye_z) - DFW'(in_target_z);
    dside_r <= {in_upward_x, in_upward_y, in_upward_z, in_eye_x, in_eye_y, in_eye_z};
  end

  // n
  logic                 nv;
  logic signed [OW-1:0] nn0, nn1, nn2;
  logic                 nzero;
  logic [SNW-1:0]       nside;
  logic signed [CW-1:0] up0, up1, up2, e0, e1, e2;

  lacb_norm #(.IW(DFW), .FB(FRAC_BITS), .SW(SNW)) u_norm_n (
    .clk(clk), .rst_n(rst_n), .in_valid(dv_r),
    .in_c0(dn_r[0]), .in_c1(dn_r[1]), .in_c2(dn_r[2]), .in_side(dside_r),
    .out_valid(nv), .out_c0(nn0), .out_c1(nn1), .out_c2(nn2),
    .out_zero(nzero), .out_side(nside)
  );

  assign {up0, up1, up2, e0, e1, e2} = nside;

  // u = up x n
  logic                 cuv;
  logic signed [UW-1:0] cu0, cu1, cu2;
  logic [SUW-1:0]       cuside;

  lacb_cross #(.AW(CW), .BW(OW), .SW(SUW)) u_cross_u (
    .clk(clk), .rst_n(rst_n), .in_valid(nv),
    .in_a0(up0), .in_a1(up1), .in_a2(up2),
    .in_b0(nn0), .in_b1(nn1), .in_b2(nn2),
    .in_side({nn0, nn1, nn2, e0, e1, e2, nzero}),
    .out_valid(cuv), .out_r0(cu0), .out_r1(cu1), .out_r2(cu2), .out_side(cuside)
  );

  logic                 uv;
  logic signed [OW-1:0] uu0, uu1, uu2;
  logic                 uzero;
  logic [SUW-1:0]       uside;
  logic signed [OW-1:0] un0, un1, un2;
  logic signed [CW-1:0] ue0, ue1, ue2;
  logic                 udeg;

  lacb_norm #(.IW(UW), .FB(FRAC_BITS), .SW(SUW)) u_norm_u (
    .clk(clk), .rst_n(rst_n), .in_valid(cuv),
    .in_c0(cu0), .in_c1(cu1), .in_c2(cu2), .in_side(cuside),
    .out_valid(uv), .out_c0(uu0), .out_c1(uu1), .out_c2(uu2),
    .out_zero(uzero), .out_side(uside)
  );

  assign {un0, un1, un2, ue0, ue1, ue2, udeg} = uside;

  // v = n x u
  logic                 cvv;
  logic signed [VW-1:0] cv0, cv1, cv2;
  logic [SVW-1:0]       cvside;

  lacb_cross #(.AW(OW), .BW(OW), .SW(SVW)) u_cross_v (
    .clk(clk), .rst_n(rst_n), .in_valid(uv),
    .in_a0(un0), .in_a1(un1), .in_a2(un2),
    .in_b0(uu0), .in_b1(uu1), .in_b2(uu2),
    .in_side({uu0, uu1, uu2, un0, un1, un2, ue0, ue1, ue2, udeg || uzero}),
    .out_valid(cvv), .out_r0(cv0), .out_r1(cv1), .out_r2(cv2), .out_side(cvside)
  );

  logic                 vv;
  logic signed [OW-1:0] vv0, vv1, vv2;
  logic                 vzero;
  logic [SVW-1:0]       vside;
  logic signed [OW-1:0] fu0, fu1, fu2, fn0, fn1, fn2;
  logic signed [CW-1:0] fe0, fe1, fe2;
  logic                 fdeg;

  lacb_norm #(.IW(VW), .FB(FRAC_BITS), .SW(SVW)) u_norm_v (
    .clk(clk), .rst_n(rst_n), .in_valid(cvv),
    .in_c0(cv0), .in_c1(cv1), .in_c2(cv2), .in_side(cvside),
    .out_valid(vv), .out_c0(vv0), .out_c1(vv1), .out_c2(vv2),
    .out_zero(vzero), .out_side(vside)
  );

  assign {fu0, fu1, fu2, fn0, fn1, fn2, fe0, fe1, fe2, fdeg} = vside;

  // row serializer
  logic                     act_r;
  logic                     act_nxt;
  logic [ROW_W-1:0]         row_r;
  logic [ROW_W-1:0]         row_nxt;
  logic signed [COMP_W-1:0] hu_r [3];
  logic signed [COMP_W-1:0] hv_r [3];
  logic signed [COMP_W-1:0] hn_r [3];
  logic signed [CW-1:0]     he_r [3];
  logic                     hdeg_r;

  always_comb begin
    act_nxt = act_r;
    row_nxt = row_r;
    if (vv) begin
      act_nxt = 1'b1;
      row_nxt = ROW_FIRST;
    end else if (act_r) begin
      if (row_r == ROW_LAST) begin
        act_nxt = 1'b0;
      end else begin
        row_nxt = row_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      row_r <= ROW_FIRST;
    end else begin
      act_r <= act_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (vv) begin
      hu_r[0] <= COMP_W'(fu0);
      hu_r[1] <= COMP_W'(fu1);
      hu_r[2] <= COMP_W'(fu2);
      hv_r[0] <= COMP_W'(vv0);
      hv_r[1] <= COMP_W'(vv1);
      hv_r[2] <= COMP_W'(vv2);
      hn_r[0] <= COMP_W'(fn0);
      hn_r[1] <= COMP_W'(fn1);
      hn_r[2] <= COMP_W'(fn2);
      he_r[0] <= fe0;
      he_r[1] <= fe1;
      he_r[2] <= fe2;
      hdeg_r  <= fdeg || vzero;
    end
  end

  assign out_strobe       = act_r;
  assign out_row_index    = row_r;
  assign out_right_comp   = hu_r[row_r];
  assign out_true_up_comp = hv_r[row_r];
  assign out_back_comp    = hn_r[row_r];
  assign out_translation  = he_r[row_r];
  assign out_last_row     = (row_r == ROW_LAST);
  assign out_degenerate   = hdeg_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accepted transaction");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    vv |-> (!act_r || row_r == ROW_LAST))
    else $error("new result arrived while rows still pending");

  a_burst_of_three: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_row_index == ROW_FIRST) |-> ##2 (out_strobe && out_last_row))
    else $error("row burst did not complete in three cycles");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import lacb_pkg::*;

  typedef longint vec_t [3];
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    logic [ROW_W-1:0]          row;
    logic signed [COMP_W-1:0]  right;
    logic signed [COMP_W-1:0]  upc;
    logic signed [COMP_W-1:0]  back;
    logic signed [COORD_W-1:0] trans;
    logic                      last;
    logic                      degen;
  } row_t;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  coord_t in_eye_x, in_eye_y, in_eye_z;
  coord_t in_target_x, in_target_y, in_target_z;
  coord_t in_upward_x, in_upward_y, in_upward_z;
  logic out_strobe;
  logic [ROW_W-1:0] out_row_index;
  logic signed [COMP_W-1:0] out_right_comp, out_true_up_comp, out_back_comp;
  coord_t out_translation;
  logic out_last_row, out_degenerate;

  row_t rows_q[$];
  int errors = 0;
  int cycles = 0;
  int gap_pct = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  look_at_camera_basis_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_eye_x(in_eye_x), .in_eye_y(in_eye_y), .in_eye_z(in_eye_z),
    .in_target_x(in_target_x), .in_target_y(in_target_y), .in_target_z(in_target_z),
    .in_upward_x(in_upward_x), .in_upward_y(in_upward_y), .in_upward_z(in_upward_z),
    .out_strobe(out_strobe), .out_row_index(out_row_index),
    .out_right_comp(out_right_comp), .out_true_up_comp(out_true_up_comp),
    .out_back_comp(out_back_comp), .out_translation(out_translation),
    .out_last_row(out_last_row), .out_degenerate(out_degenerate)
  );

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= res + b) begin
        a -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // returns 1 on zero length
  function automatic bit unit_vec(inout vec_t c);
    longint unsigned m[3];
    bit neg[3];
    longint unsigned mx = 0, sum = 0, len, q;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      m[i] = neg[i] ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      c = '{0, 0, 0};
      return 1'b1;
    end
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC_BITS_DEF) + (len >> 1)) / len;
      if (q > (64'd1 << FRAC_BITS_DEF)) q = 64'd1 << FRAC_BITS_DEF;
      c[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic vec_t cross_prod(vec_t a, vec_t b);
    vec_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  task automatic predict_basis(coord_t e[3], coord_t t[3], coord_t up[3]);
    vec_t n, u, v, upv;
    bit dg = 0;
    row_t r;
    for (int i = 0; i < 3; i++) begin
      n[i] = longint'(e[i]) - longint'(t[i]);
      upv[i] = longint'(up[i]);
    end
    dg |= unit_vec(n);
    u = cross_prod(upv, n);
    dg |= unit_vec(u);
    v = cross_prod(n, u);
    dg |= unit_vec(v);
    for (int i = 0; i < 3; i++) begin
      r.row = ROW_W'(i);
      r.right = u[i][COMP_W-1:0];
      r.upc = v[i][COMP_W-1:0];
      r.back = n[i][COMP_W-1:0];
      r.trans = e[i];
      r.last = (r.row == ROW_LAST);
      r.degen = dg;
      rows_q = {rows_q, r};
    end
  endtask

  // start is left high after acceptance; the next call lowers it only for a gap
  task automatic send_camera(coord_t e[3], coord_t t[3], coord_t up[3]);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    {in_eye_x, in_eye_y, in_eye_z} <= {e[0], e[1], e[2]};
    {in_target_x, in_target_y, in_target_z} <= {t[0], t[1], t[2]};
    {in_upward_x, in_upward_y, in_upward_z} <= {up[0], up[1], up[2]};
    do @(posedge clk); while (busy);
    predict_basis(e, t, up);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb failed");
      $finish;
    end
    if (rst_n && out_strobe) begin
      if (rows_q.size() == 0) begin
        $error("unexpected row %0d", out_row_index);
        errors++;
      end else begin
        row_t x;
        x = rows_q.pop_front();
        if (x.row !== out_row_index) begin
          $error("row_index exp %0d got %0d", x.row, out_row_index); errors++;
        end
        if (x.right !== out_right_comp) begin
          $error("right_comp exp %0d got %0d", x.right, out_right_comp); errors++;
        end
        if (x.upc !== out_true_up_comp) begin
          $error("true_up_comp exp %0d got %0d", x.upc, out_true_up_comp);
          errors++;
        end
        if (x.back !== out_back_comp) begin
          $error("back_comp exp %0d got %0d", x.back, out_back_comp); errors++;
        end
        if (x.trans !== out_translation) begin
          $error("translation exp %0d got %0d", x.trans, out_translation);
          errors++;
        end
        if (x.last !== out_last_row) begin
          $error("last_row exp %0d got %0d", x.last, out_last_row); errors++;
        end
        if (x.degen !== out_degenerate) begin
          $error("degenerate exp %0d got %0d", x.degen, out_degenerate);
          errors++;
        end
      end
    end
  end

  function automatic coord_t rnd_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom());
      1: return coord_t'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      2: return coord_t'($signed($urandom_range(0, 64)) - 32);
      default: return coord_t'($urandom_range(1) ? 32'h7fffffff : 32'h80000000);
    endcase
  endfunction

  task automatic test_directed();
    coord_t mx = 32'sh7fffffff, mn = 32'sh80000000, one = 32'sh10000;
    send_camera('{0, 0, one}, '{0, 0, 0}, '{0, one, 0});
    send_camera('{one, 2 * one, 3 * one}, '{-one, 0, one}, '{0, one, 0});
    send_camera('{5, 5, 5}, '{5, 5, 5}, '{0, one, 0});
    send_camera('{0, 0, one}, '{0, 0, 0}, '{0, 0, one});
    send_camera('{0, 0, one}, '{0, 0, 0}, '{0, 0, 0});
    send_camera('{mx, mx, mx}, '{mn, mn, mn}, '{mn, mx, 0});
    send_camera('{mn, mx, mn}, '{mx, mn, mx}, '{mx, mn, mn});
    send_camera('{mn, 0, 0}, '{mx, 0, 0}, '{0, mn, 0});
    send_camera('{mx, 0, 0}, '{0, 0, 0}, '{0, 0, mx});
    send_camera('{1, 0, 0}, '{0, 0, 0}, '{0, 1, 0});
    send_camera('{-1, -1, -1}, '{0, 0, 0}, '{-1, 1, -1});
    send_camera('{0, 0, 0}, '{one, one, 0}, '{0, 0, -one});
    send_camera('{32'sh12345678, -32'sh0fedcba9, 7}, '{0, 0, 0}, '{mx, mx, mx});
  endtask

  task automatic test_random(int n_items);
    coord_t e[3], t[3], up[3];
    for (int k = 0; k < n_items; k++) begin
      for (int i = 0; i < 3; i++) begin
        e[i] = rnd_coord(); t[i] = rnd_coord(); up[i] = rnd_coord();
      end
      case ($urandom_range(9))
        0: t = e;
        1: for (int i = 0; i < 3; i++) up[i] = (e[i] - t[i]) >>> 2;
        2: up = '{0, 0, 0};
        default: ;
      endcase
      send_camera(e, t, up);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    {in_eye_x, in_eye_y, in_eye_z} <= '0;
    {in_target_x, in_target_y, in_target_z} <= '0;
    {in_upward_x, in_upward_y, in_upward_z} <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    gap_pct = 35;
    test_random(120);
    gap_pct = 45;
    test_random(120);
    gap_pct = 0;
    test_random(120);
    start <= 1'b0;
    while (rows_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && rows_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/lacb_pkg.sv
hw/rtl/lacb_cross.sv
hw/rtl/lacb_norm.sv
hw/rtl/look_at_camera_basis_top.sv
test/tb.sv
